[sv/dmc_pkg.sv]
// Shared widths, constants and controller/datapath handshake types for the cache block.
`default_nettype none

package dmc_pkg;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;

  localparam logic [7:0]       TAG_RESET = 8'hFF;
  localparam logic [CNT_W-1:0] MISS_TIME = 32'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic div1;
    logic mem_write;
    logic div2;
    logic div3;
    logic look;
    logic fill_rd;
    logic fill_wr;
    logic line_rd;
    logic out_load;
  } dmc_cmd_t;

  typedef struct packed {
    logic func;
    logic hit;
    logic fill_last;
  } dmc_sts_t;

endpackage

`default_nettype wire

[sv/dmc_if.sv]
// Request and response channel interfaces of the cache block.
`default_nettype none

interface dmc_req_if import dmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output func, output address, output write_data, input ready);
  modport sink   (input valid, input func, input address, input write_data, output ready);
endinterface

interface dmc_rsp_if import dmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_byte;
  logic [CNT_W-1:0]  time_total;
  logic [CNT_W-1:0]  miss_count;
  logic [CNT_W-1:0]  access_count;

  modport source (output valid, output hit, output read_byte, output time_total,
                  output miss_count, output access_count, input ready);
  modport sink   (input valid, input hit, input read_byte, input time_total,
                  input miss_count, input access_count, output ready);
endinterface

`default_nettype wire

[sv/direct_mapped_cache_access.sv]
// Top level of the direct-mapped cache: state machine plus datapath.
//
// Requests arrive on req_i. func = 0 stores write_data into the backing memory at
// address modulo the memory size; func = 1 looks the address up in the cache. Each
// request gives exactly one response on rsp_o with the hit flag, the line byte at the
// word offset (both zero for a write) and the time, miss and access counters (all
// saturating). A memory write passes through DIV1, WRITE and DONE; an access through
// DIV1, DIV2, DIV3 and LOOK, then on a miss through one FRD/FWR pair per byte of the
// line, then RD and DONE. The line is refilled one byte per read-then-write pair,
// each byte read from the byte-wide backing memory and then written into the line
// store. One request is in flight at a time; the next one is taken in the cycle
// after the response is registered.
// The response sits in an output register; while the receiver stalls, the block
// still accepts and works on the next request and waits only when that one is done.
// Reset clears the counters, sets every tag to 0xFF and marks every line as holding
// zeros; the backing memory is not cleared and must be written before a miss reads it.
`default_nettype none

module direct_mapped_cache_access import dmc_pkg::*; #(
  parameter int LINE_COUNT     = 4,
  parameter int BYTES_PER_LINE = 8,
  parameter int MEMORY_BYTES   = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dmc_req_if.sink    req_i,
  dmc_rsp_if.source  rsp_o
);

  dmc_cmd_t cmd;
  dmc_sts_t sts;

  dmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmc_dp #(
    .LINE_COUNT     (LINE_COUNT),
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .MEMORY_BYTES   (MEMORY_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (req_i.func),
    .address_i      (req_i.address),
    .write_data_i   (req_i.write_data),
    .hit_o          (rsp_o.hit),
    .read_byte_o    (rsp_o.read_byte),
    .time_total_o   (rsp_o.time_total),
    .miss_count_o   (rsp_o.miss_count),
    .access_count_o (rsp_o.access_count)
  );

endmodule

`default_nettype wire

[sv/dmc_ctrl.sv]
// Sequencing state machine of the cache block.
`default_nettype none

module dmc_ctrl import dmc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dmc_sts_t sts_i,
  output dmc_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_DIV2  = 4'd3;
  localparam logic [3:0] S_DIV3  = 4'd4;
  localparam logic [3:0] S_LOOK  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d    = sts_i.func ? S_DIV2 : S_WRITE;
      end
      S_WRITE: begin
        cmd_o.mem_write = 1'b1;
        state_d         = S_DONE;
      end
      S_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d    = S_DIV3;
      end
      S_DIV3: begin
        cmd_o.div3 = 1'b1;
        state_d    = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = sts_i.hit ? S_RD : S_FRD;
      end
      S_FRD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_FWR;
      end
      S_FWR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = sts_i.fill_last ? S_RD : S_FRD;
      end
      S_RD: begin
        cmd_o.line_rd = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // Hold the finished request until the output register is free.
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[sv/dmc_dp.sv]
// Address split, tag store, line store, backing memory and counters of the cache block.
`default_nettype none

module dmc_dp import dmc_pkg::*; #(
  parameter int LINE_COUNT     = 4,
  parameter int BYTES_PER_LINE = 8,
  parameter int MEMORY_BYTES   = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dmc_cmd_t          cmd_i,
  output dmc_sts_t               sts_o,
  input  wire logic              func_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic                   hit_o,
  output logic [DATA_W-1:0]      read_byte_o,
  output logic [CNT_W-1:0]       time_total_o,
  output logic [CNT_W-1:0]       miss_count_o,
  output logic [CNT_W-1:0]       access_count_o
);

  localparam int ADDR_MAX = (1 << ADDR_W) - 1;
  localparam int BLK_W    = $clog2(ADDR_MAX / BYTES_PER_LINE + 1);
  localparam int TAG_W    = $clog2(ADDR_MAX / (LINE_COUNT * BYTES_PER_LINE) + 1);
  localparam int TS_W     = (TAG_W > 8) ? TAG_W : 8;
  localparam int WORD_W   = $clog2(BYTES_PER_LINE);
  localparam int LN_W     = $clog2(LINE_COUNT);
  localparam int LB_W     = $clog2(LINE_COUNT * BYTES_PER_LINE);
  localparam int MA_W     = $clog2(MEMORY_BYTES);
  localparam int XW       = $clog2(ADDR_MAX + BYTES_PER_LINE);
  localparam int QM_W     = $clog2((ADDR_MAX + BYTES_PER_LINE - 1) / MEMORY_BYTES + 1);
  localparam int LDEPTH   = LINE_COUNT * BYTES_PER_LINE;

  // Division by a constant as multiplication by a rounded-up reciprocal; exact for
  // every dividend of the given width.
  localparam int SB = ADDR_W + $clog2(BYTES_PER_LINE);
  localparam longint unsigned MB =
      ((64'd1 << SB) + BYTES_PER_LINE - 1) / BYTES_PER_LINE;
  localparam int ST = BLK_W + $clog2(LINE_COUNT);
  localparam longint unsigned MT = ((64'd1 << ST) + LINE_COUNT - 1) / LINE_COUNT;
  localparam int SM = XW + $clog2(MEMORY_BYTES);
  localparam longint unsigned MM = ((64'd1 << SM) + MEMORY_BYTES - 1) / MEMORY_BYTES;

  localparam int PB_W = SB + BLK_W;
  localparam int PT_W = ST + TAG_W;
  localparam int PM_W = SM + QM_W;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (a > COUNT_MAX - b) ? COUNT_MAX : a + b;
  endfunction

  logic              func_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic [BLK_W-1:0]  blk_q;
  logic [TAG_W-1:0]  tag_q;
  logic [WORD_W-1:0] word_q;
  logic [LN_W-1:0]   line_q;
  logic [XW-1:0]     modx_q;
  logic [QM_W-1:0]   modq_q;
  logic [MA_W-1:0]   ptr_q;
  logic [WORD_W-1:0] idx_q;
  logic              hit_q;
  logic [DATA_W-1:0] mem_rd_q;
  logic [DATA_W-1:0] line_rd_q;

  logic [TS_W-1:0]       tags_q [LINE_COUNT];
  logic [LINE_COUNT-1:0] line_valid_q;
  logic [CNT_W-1:0]      time_q, miss_q, acc_q;

  logic [DATA_W-1:0] line_mem [LDEPTH];
  logic [DATA_W-1:0] back_mem [MEMORY_BYTES];

  logic [PB_W-1:0]   blk_prod;
  logic [PT_W-1:0]   tag_prod;
  logic [PM_W-1:0]   mod_prod;
  logic [BLK_W-1:0]  blk_d;
  logic [TAG_W-1:0]  tag_d;
  logic [QM_W-1:0]   modq_d;
  logic [WORD_W-1:0] word_d;
  logic [LN_W-1:0]   line_d;
  logic [XW-1:0]     fill_start;
  logic [MA_W-1:0]   mod_rem;
  logic [MA_W-1:0]   ptr_dec;
  logic [LB_W-1:0]   line_base;
  logic              tag_match;

  assign blk_prod = PB_W'(addr_q) * PB_W'(MB);
  assign blk_d    = blk_prod[SB +: BLK_W];
  assign tag_prod = PT_W'(blk_q) * PT_W'(MT);
  assign tag_d    = tag_prod[ST +: TAG_W];
  assign mod_prod = PM_W'(modx_q) * PM_W'(MM);
  assign modq_d   = mod_prod[SM +: QM_W];

  assign word_d = WORD_W'(addr_q - ADDR_W'(blk_q) * ADDR_W'(BYTES_PER_LINE));
  assign line_d = LN_W'(blk_q - BLK_W'(tag_q) * BLK_W'(LINE_COUNT));
  // Last byte of the block: the fill walks the block downward from here.
  assign fill_start = XW'(blk_q) * XW'(BYTES_PER_LINE) + XW'(BYTES_PER_LINE - 1);
  assign mod_rem    = MA_W'(modx_q - XW'(modq_q) * XW'(MEMORY_BYTES));
  assign ptr_dec    = (ptr_q == '0) ? MA_W'(MEMORY_BYTES - 1) : ptr_q - 1'b1;
  assign line_base  = LB_W'(line_q) * LB_W'(BYTES_PER_LINE);

  assign tag_match = (tags_q[line_q] == TS_W'(tag_q));

  assign sts_o.func      = func_q;
  assign sts_o.hit       = tag_match;
  assign sts_o.fill_last = (idx_q == WORD_W'(BYTES_PER_LINE - 1));

  // Control state: tag store, line valid bits, counters and the fill index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINE_COUNT; k++) begin
        tags_q[k] <= TS_W'(TAG_RESET);
      end
      line_valid_q <= '0;
      time_q       <= '0;
      miss_q       <= '0;
      acc_q        <= '0;
      idx_q        <= '0;
    end else begin
      if (cmd_i.look) begin
        acc_q <= sat_add(acc_q, CNT_W'(1));
        idx_q <= '0;
        if (tag_match) begin
          time_q <= sat_add(time_q, CNT_W'(1));
        end else begin
          time_q               <= sat_add(time_q, MISS_TIME);
          miss_q               <= sat_add(miss_q, CNT_W'(1));
          tags_q[line_q]       <= TS_W'(tag_q);
          line_valid_q[line_q] <= 1'b1;
        end
      end
      if (cmd_i.fill_wr) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      addr_q <= address_i;
      data_q <= write_data_i;
      modx_q <= XW'(address_i);
    end
    if (cmd_i.div1) begin
      blk_q  <= blk_d;
      modq_q <= modq_d;
    end
    if (cmd_i.div2) begin
      word_q <= word_d;
      tag_q  <= tag_d;
      modx_q <= fill_start;
    end
    if (cmd_i.div3) begin
      line_q <= line_d;
      modq_q <= modq_d;
    end
    if (cmd_i.look) begin
      hit_q <= tag_match;
      ptr_q <= mod_rem;
    end
    if (cmd_i.fill_wr) begin
      ptr_q <= ptr_dec;
    end
    if (cmd_i.out_load) begin
      hit_o          <= func_q & hit_q;
      read_byte_o    <= (func_q && line_valid_q[line_q]) ? line_rd_q : '0;
      time_total_o   <= time_q;
      miss_count_o   <= miss_q;
      access_count_o <= acc_q;
    end
  end

  // Backing memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      back_mem[mod_rem] <= data_q;
    end
    if (cmd_i.fill_rd) begin
      mem_rd_q <= back_mem[ptr_q];
    end
  end

  // Line store: filled one byte at a time, read once per access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr) begin
      line_mem[line_base + LB_W'(idx_q)] <= mem_rd_q;
    end
    if (cmd_i.line_rd) begin
      line_rd_q <= line_mem[line_base + LB_W'(word_q)];
    end
  end

endmodule

`default_nettype wire

[tb/dmc_tb_pkg.sv]
// Scoreboard package for the direct-mapped cache testbench: sizes, result type and checker.
`timescale 1ns / 1ps

package dmc_tb_pkg;
  import dmc_pkg::*;

  localparam int CACHE_LINES  = 4;
  localparam int LINE_BYTES   = 8;
  localparam int MEM_BYTES    = 1024;
  localparam int TAG_W        = ADDR_W - $clog2(LINE_BYTES) - $clog2(CACHE_LINES);
  localparam int REPORT_LIMIT = 50;

  localparam bit FUNC_WRITE  = 1'b0;
  localparam bit FUNC_ACCESS = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_byte;
    logic [CNT_W-1:0]  time_total;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  access_count;
  } cache_result_t;

  class cache_scoreboard;
    bit [TAG_W-1:0]  tag_of_line[CACHE_LINES];
    bit [DATA_W-1:0] line_data[CACHE_LINES*LINE_BYTES];
    bit [DATA_W-1:0] backing[MEM_BYTES];
    bit [CNT_W-1:0]  elapsed;
    bit [CNT_W-1:0]  miss_total;
    bit [CNT_W-1:0]  access_total;
    cache_result_t   expected_results[$];
    int              errors;

    function new();
      foreach (tag_of_line[i]) tag_of_line[i] = TAG_W'(TAG_RESET);
      foreach (line_data[i]) line_data[i] = '0;
      foreach (backing[i]) backing[i] = '0;
      elapsed      = '0;
      miss_total   = '0;
      access_total = '0;
      errors       = 0;
    endfunction

    function bit [CNT_W-1:0] sat_add(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
      return (a > COUNT_MAX - b) ? COUNT_MAX : a + b;
    endfunction

    function bit tag_matches(bit [ADDR_W-1:0] addr);
      int block;
      block = addr / LINE_BYTES;
      return tag_of_line[block % CACHE_LINES] == TAG_W'(block / CACHE_LINES);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Updates the cache image for an accepted request and queues the response it must give.
    function void note_request(bit func, bit [ADDR_W-1:0] addr, bit [DATA_W-1:0] data);
      cache_result_t want;
      int word, block, line, base, start;
      want = '0;
      if (func == FUNC_WRITE) begin
        backing[addr % MEM_BYTES] = data;
      end else begin
        word  = addr % LINE_BYTES;
        block = addr / LINE_BYTES;
        line  = block % CACHE_LINES;
        base  = line * LINE_BYTES;
        if (tag_of_line[line] == TAG_W'(block / CACHE_LINES)) begin
          want.hit = 1'b1;
          elapsed  = sat_add(elapsed, 1);
        end else begin
          miss_total        = sat_add(miss_total, 1);
          elapsed           = sat_add(elapsed, MISS_TIME);
          tag_of_line[line] = TAG_W'(block / CACHE_LINES);
          start             = block * LINE_BYTES;
          // The line is filled back to front, wrapping around the end of memory.
          for (int i = 0; i < LINE_BYTES; i++)
            line_data[base + i] = backing[(start + LINE_BYTES - 1 - i) % MEM_BYTES];
        end
        access_total   = sat_add(access_total, 1);
        want.read_byte = line_data[base + word];
      end
      want.time_total   = elapsed;
      want.miss_count   = miss_total;
      want.access_count = access_total;
      expected_results.push_back(want);
    endfunction

    task report(string what);
      if (errors < REPORT_LIMIT) $display("[%0t] %s", $time, what);
      errors++;
    endtask

    task check_response(cache_result_t got);
      cache_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("response with no request outstanding: hit=%0b byte=%02h",
                         got.hit, got.read_byte));
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit: got %0b, want %0b", got.hit, want.hit));
      if (got.read_byte !== want.read_byte)
        report($sformatf("read_byte: got %02h, want %02h", got.read_byte, want.read_byte));
      if (got.time_total !== want.time_total)
        report($sformatf("time_total: got %0d, want %0d", got.time_total, want.time_total));
      if (got.miss_count !== want.miss_count)
        report($sformatf("miss_count: got %0d, want %0d", got.miss_count, want.miss_count));
      if (got.access_count !== want.access_count)
        report($sformatf("access_count: got %0d, want %0d",
                         got.access_count, want.access_count));
    endtask

    task flag_leftovers();
      while (expected_results.size() != 0) begin
        void'(expected_results.pop_front());
        report("expected response never arrived");
      end
    endtask
  endclass

endpackage

[tb/tb_top.sv]
// Top of the direct-mapped cache testbench: clock, reset, request driver and response checker.
`timescale 1ns / 1ps

module tb_top;
  import dmc_pkg::*;
  import dmc_tb_pkg::*;

  localparam int ITEM_TARGET    = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk;
  logic rst_n;

  dmc_req_if req_if ();
  dmc_rsp_if rsp_if ();

  direct_mapped_cache_access #(
    .LINE_COUNT    (CACHE_LINES),
    .BYTES_PER_LINE(LINE_BYTES),
    .MEMORY_BYTES  (MEM_BYTES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  cache_scoreboard sb;
  bit              calm;
  int              items_sent;
  int              quiet_cycles;
  bit              byte_written[MEM_BYTES];
  bit              group_ready[MEM_BYTES/LINE_BYTES];
  int              ready_groups[$];
  cache_result_t   observed;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none at all during a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(bit f, bit [ADDR_W-1:0] a, bit [DATA_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.address    <= a;
    req_if.write_data <= d;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(f, a, d);
    items_sent++;
  endtask

  // A miss may only be caused once every byte of its memory block has been written.
  task automatic write_byte(bit [ADDR_W-1:0] a, bit [DATA_W-1:0] d);
    int idx, g;
    bit whole;
    idx = a % MEM_BYTES;
    g   = idx / LINE_BYTES;
    byte_written[idx] = 1'b1;
    if (!group_ready[g]) begin
      whole = 1'b1;
      for (int i = 0; i < LINE_BYTES; i++) whole &= byte_written[g*LINE_BYTES + i];
      if (whole) begin
        group_ready[g] = 1'b1;
        ready_groups.push_back(g);
      end
    end
    send_request(FUNC_WRITE, a, d);
  endtask

  task automatic read_line(bit [ADDR_W-1:0] a);
    send_request(FUNC_ACCESS, a, DATA_W'($urandom));
  endtask

  initial begin
    bit [ADDR_W-1:0] a;
    int kind, g, hi, n, w, w0, l;
    sb                = new();
    calm              = 1'b0;
    items_sent        = 0;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_WRITE;
    req_if.address    = '0;
    req_if.write_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Lines start with tag 0xFF, so these hit before anything is filled.
    read_line(16'h1FE0);
    read_line(16'h1FFF);
    write_byte(16'h0000, 8'h00);
    write_byte(16'h0001, 8'hFF);
    write_byte(16'h0002, 8'h01);
    write_byte(16'h0003, 8'h80);
    write_byte(16'h0004, 8'h55);
    write_byte(16'h0005, 8'hAA);
    write_byte(16'h0006, 8'h7F);
    write_byte(16'h0007, 8'hFE);
    read_line(16'h0000);
    read_line(16'h0007);
    // This block lies far beyond memory and wraps onto the bytes just written.
    read_line(16'hFC03);
    // The top address wraps into the last memory block.
    write_byte(16'hFFFF, 8'hFF);
    for (int i = 0; i < LINE_BYTES - 1; i++)
      write_byte(ADDR_W'(16'h03F8 + i), DATA_W'(8'h11 * (i + 1)));
    read_line(16'hFFF8);
    read_line(16'hFFFF);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // Fill a whole memory block, then read it through one or more tags.
        g  = $urandom_range(0, MEM_BYTES/LINE_BYTES - 1);
        hi = $urandom_range(0, 63);
        w0 = $urandom_range(0, LINE_BYTES - 1);
        for (int i = 0; i < LINE_BYTES; i++)
          write_byte({6'(hi), 7'(g), 3'((w0 + i) % LINE_BYTES)}, DATA_W'($urandom));
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) == 0) hi = $urandom_range(0, 63);
          read_line({6'(hi), 7'(g), 3'($urandom_range(0, LINE_BYTES - 1))});
        end
      end else if (kind < 75) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          w = $urandom_range(0, LINE_BYTES - 1);
          if ($urandom_range(0, 9) < 6 || ready_groups.size() == 0) begin
            l = $urandom_range(0, CACHE_LINES - 1);
            a = {sb.tag_of_line[l], 2'(l), 3'(w)};
          end else begin
            g  = ready_groups[$urandom_range(0, ready_groups.size() - 1)];
            hi = $urandom_range(0, 63);
            a  = {6'(hi), 7'(g), 3'(w)};
          end
          read_line(a);
        end
      end else if (kind < 88) begin
        write_byte(ADDR_W'($urandom), DATA_W'($urandom));
      end else begin
        // A block that is only partly written.
        g  = $urandom_range(0, MEM_BYTES/LINE_BYTES - 1);
        hi = $urandom_range(0, 63);
        n  = $urandom_range(1, LINE_BYTES - 1);
        for (int i = 0; i < n; i++)
          write_byte({6'(hi), 7'(g), 3'($urandom_range(0, LINE_BYTES - 1))},
                     DATA_W'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : rsp_stall
    int stall_left;
    bit next_ready;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || calm) begin
        next_ready = rst_n;
        stall_left = 0;
      end else if (stall_left > 0) begin
        next_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        next_ready = (stall_left == 0);
      end else begin
        next_ready = 1'b1;
      end
      rsp_if.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      observed.hit          = rsp_if.hit;
      observed.read_byte    = rsp_if.read_byte;
      observed.time_total   = rsp_if.time_total;
      observed.miss_count   = rsp_if.miss_count;
      observed.access_count = rsp_if.access_count;
      sb.check_response(observed);
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

[direct_mapped_cache_access.f]
sv/dmc_pkg.sv
sv/dmc_if.sv
sv/dmc_ctrl.sv
sv/dmc_dp.sv
sv/direct_mapped_cache_access.sv
tb/dmc_tb_pkg.sv
tb/tb_top.sv
